[rtl/lfra_pkg.sv]
// Shared constants, types and helper functions for the lowest free room allocator.
`timescale 1ns / 1ps

package lfra_pkg;

  // Table sizes
  localparam int MAX_CUSTOMERS = 1024;
  localparam int MAX_ROOMS     = 1024;
  localparam int WORD_W        = 64;
  localparam int MAP_WORDS     = MAX_ROOMS / WORD_W;

  // Field and index widths
  localparam int CUST_W  = $clog2(MAX_CUSTOMERS);
  localparam int ROOM_W  = $clog2(MAX_ROOMS + 1);
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int WADDR_W = $clog2(MAP_WORDS);

  // Event codes
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_DEPART = 1'b1;

  // Customer table port
  typedef struct packed {
    logic              rd_en;
    logic [CUST_W-1:0] rd_addr;
    logic              wr_en;
    logic [CUST_W-1:0] wr_addr;
    logic [ROOM_W-1:0] wr_data;
  } cust_req_t;

  // Busy map port
  typedef struct packed {
    logic               rd_en;
    logic [WADDR_W-1:0] rd_addr;
    logic               wr_en;
    logic [WADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;
  } busy_req_t;

  // Busy map status back to the controller
  typedef struct packed {
    logic [WORD_W-1:0]  rd_data;
    logic               any_free;
    logic [WADDR_W-1:0] free_word;
  } busy_rsp_t;

  // Index of the lowest clear bit in a map word
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // Index of the lowest map word that is not completely full
  function automatic logic [WADDR_W-1:0] lowest_open(input logic [MAP_WORDS-1:0] full);
    logic [WADDR_W-1:0] idx;
    idx = '0;
    for (int i = MAP_WORDS - 1; i >= 0; i--) begin
      if (!full[i]) idx = WADDR_W'(i);
    end
    return idx;
  endfunction

endpackage

[rtl/lfra_cust_mem.sv]
// Customer-to-room table: single write port, single registered read port.
`timescale 1ns / 1ps

module lfra_cust_mem (
  input  logic                         clk,
  input  lfra_pkg::cust_req_t          req,
  output logic [lfra_pkg::ROOM_W-1:0]  rd_data
);

  logic [lfra_pkg::ROOM_W-1:0] mem [lfra_pkg::MAX_CUSTOMERS];
  logic [lfra_pkg::ROOM_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read port, registered; data holds until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/lfra_busy_map.sv]
// Room occupancy bitmap: word memory with per-word valid and full flags.
`timescale 1ns / 1ps

module lfra_busy_map (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lfra_pkg::busy_req_t  req,
  output lfra_pkg::busy_rsp_t  rsp
);

  logic [lfra_pkg::WORD_W-1:0]    mem [lfra_pkg::MAP_WORDS];
  logic [lfra_pkg::WORD_W-1:0]    rd_data_r;
  logic                           rd_valid_r;
  logic [lfra_pkg::MAP_WORDS-1:0] valid_r;
  logic [lfra_pkg::MAP_WORDS-1:0] full_r;

  // Word storage
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  // Valid and full flags; a word never written reads as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      full_r     <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
        full_r[req.wr_addr]  <= &req.wr_data;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rsp.rd_data   = rd_valid_r ? rd_data_r : '0;
  assign rsp.any_free  = ~&full_r;
  assign rsp.free_word = lfra_pkg::lowest_open(full_r);

endmodule

[rtl/lowest_free_room_allocator.sv]
// Top level: event sequencer for the lowest free room allocator.
//
// Input channel (in_valid/in_ready): one event per transfer, in_cmd selects
// arrive or depart, in_customer names the customer. Output channel
// (out_valid/out_ready): one result per event with the room assigned, the
// rooms in use after the event, the running peak and the full flag.
//
// Timing: one event is handled at a time. An arrival, or a departure with no
// room held, reads the customer table and the busy word in parallel, then
// updates. A departure that frees a room reads the customer table, then the
// busy word of the held room, then updates. in_ready is high only while the
// sequencer is idle, so no new event is taken until the current one is done;
// the steps are set by the registered reads of the tables.
//
// The result sits in an output register; the next event is taken while it
// waits. If the receiver stalls, the following event holds in its last step,
// without touching the tables, until the output register frees up.
// Reset: all rooms free, counts zero. A clearing pass then zeroes the 1024
// customer entries, one per cycle; in_ready stays low until the pass ends.
`timescale 1ns / 1ps

module lowest_free_room_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [lfra_pkg::CUST_W-1:0]   in_customer,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lfra_pkg::ROOM_W-1:0]   out_room,
  output logic [lfra_pkg::ROOM_W-1:0]   out_occupied,
  output logic [lfra_pkg::ROOM_W-1:0]   out_peak,
  output logic                          out_full_res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_FREE  = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  lfra_pkg::cust_req_t cust_req;
  lfra_pkg::busy_req_t busy_req;
  lfra_pkg::busy_rsp_t busy_rsp;
  logic [lfra_pkg::ROOM_W-1:0] held;

  logic [1:0] state_r, state_nxt;
  logic [lfra_pkg::CUST_W-1:0]     clr_r, clr_nxt;
  logic                            cmd_r, cmd_nxt;
  logic [lfra_pkg::CUST_W-1:0]     cust_r, cust_nxt;
  logic                            any_free_r, any_free_nxt;
  logic [lfra_pkg::WADDR_W-1:0]    free_word_r, free_word_nxt;
  logic [lfra_pkg::ROOM_W-1:0]     held_r, held_nxt;
  logic [lfra_pkg::ROOM_W-1:0]     cnt_r, cnt_nxt;
  logic [lfra_pkg::ROOM_W-1:0]     peak_r, peak_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [lfra_pkg::ROOM_W-1:0]     out_room_r, out_room_nxt;
  logic [lfra_pkg::ROOM_W-1:0]     out_occ_r, out_occ_nxt;
  logic [lfra_pkg::ROOM_W-1:0]     out_peak_r, out_peak_nxt;
  logic                            out_full_r, out_full_nxt;

  logic                            in_xfer;
  logic                            slot_ok;
  logic                            load;
  logic [lfra_pkg::BIT_W-1:0]      new_bit;
  logic [lfra_pkg::ROOM_W-1:0]     new_room;
  logic [lfra_pkg::ROOM_W-1:0]     held_idx;

  lfra_cust_mem u_cust (
    .clk     (clk),
    .req     (cust_req),
    .rd_data (held)
  );

  lfra_busy_map u_busy (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (busy_req),
    .rsp   (busy_rsp)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign slot_ok  = !out_valid_r || out_ready;

  // Allocation candidate and the bit position of a held room
  assign new_bit  = lfra_pkg::lowest_zero(busy_rsp.rd_data);
  assign new_room = lfra_pkg::ROOM_W'({free_word_r, new_bit}) + lfra_pkg::ROOM_W'(1);
  assign held_idx = held_r - lfra_pkg::ROOM_W'(1);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    cust_nxt      = cust_r;
    any_free_nxt  = any_free_r;
    free_word_nxt = free_word_r;
    held_nxt      = held_r;
    cnt_nxt       = cnt_r;
    cust_req      = '0;
    busy_req      = '0;
    load          = 1'b0;
    out_room_nxt  = out_room_r;
    out_full_nxt  = out_full_r;

    unique case (state_r)
      S_CLEAR: begin
        // zero one customer entry per cycle after reset
        cust_req.wr_en   = 1'b1;
        cust_req.wr_addr = clr_r;
        cust_req.wr_data = '0;
        clr_nxt          = clr_r + lfra_pkg::CUST_W'(1);
        if (clr_r == lfra_pkg::CUST_W'(lfra_pkg::MAX_CUSTOMERS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          cust_req.rd_en   = 1'b1;
          cust_req.rd_addr = in_customer;
          busy_req.rd_en   = 1'b1;
          busy_req.rd_addr = busy_rsp.free_word;
          cmd_nxt          = in_cmd;
          cust_nxt         = in_customer;
          any_free_nxt     = busy_rsp.any_free;
          free_word_nxt    = busy_rsp.free_word;
          state_nxt        = S_LOOK;
        end
      end
      S_LOOK: begin
        if (cmd_r == lfra_pkg::CMD_ARRIVE) begin
          if (slot_ok) begin
            load      = 1'b1;
            state_nxt = S_IDLE;
            if (held != '0) begin
              // already holds a room
              out_room_nxt = held;
              out_full_nxt = 1'b0;
            end else if (!any_free_r) begin
              out_room_nxt = '0;
              out_full_nxt = 1'b1;
            end else begin
              busy_req.wr_en   = 1'b1;
              busy_req.wr_addr = free_word_r;
              busy_req.wr_data = busy_rsp.rd_data
                                 | (lfra_pkg::WORD_W'(1) << new_bit);
              cust_req.wr_en   = 1'b1;
              cust_req.wr_addr = cust_r;
              cust_req.wr_data = new_room;
              cnt_nxt          = cnt_r + lfra_pkg::ROOM_W'(1);
              out_room_nxt     = new_room;
              out_full_nxt     = 1'b0;
            end
          end
        end else if (held == '0) begin
          // departure with no room held: nothing changes
          if (slot_ok) begin
            load         = 1'b1;
            out_room_nxt = '0;
            out_full_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end
        end else begin
          held_nxt         = held;
          busy_req.rd_en   = 1'b1;
          busy_req.rd_addr = lfra_pkg::WADDR_W'(
                               (held - lfra_pkg::ROOM_W'(1)) >> lfra_pkg::BIT_W);
          state_nxt        = S_FREE;
        end
      end
      S_FREE: begin
        if (slot_ok) begin
          busy_req.wr_en   = 1'b1;
          busy_req.wr_addr = lfra_pkg::WADDR_W'(held_idx >> lfra_pkg::BIT_W);
          busy_req.wr_data = busy_rsp.rd_data
                             & ~(lfra_pkg::WORD_W'(1) << held_idx[lfra_pkg::BIT_W-1:0]);
          cust_req.wr_en   = 1'b1;
          cust_req.wr_addr = cust_r;
          cust_req.wr_data = '0;
          if (cnt_r != '0) cnt_nxt = cnt_r - lfra_pkg::ROOM_W'(1);
          load         = 1'b1;
          out_room_nxt = '0;
          out_full_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
    endcase

    peak_nxt     = (cnt_nxt > peak_r) ? cnt_nxt : peak_r;
    out_occ_nxt  = load ? cnt_nxt : out_occ_r;
    out_peak_nxt = load ? peak_nxt : out_peak_r;

    // Output register occupancy
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Event and result payload
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    cust_r      <= cust_nxt;
    any_free_r  <= any_free_nxt;
    free_word_r <= free_word_nxt;
    held_r      <= held_nxt;
    out_room_r  <= out_room_nxt;
    out_occ_r   <= out_occ_nxt;
    out_peak_r  <= out_peak_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_room     = out_room_r;
  assign out_occupied = out_occ_r;
  assign out_peak     = out_peak_r;
  assign out_full_res = out_full_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= lfra_pkg::ROOM_W'(lfra_pkg::MAX_ROOMS))
    else $error("rooms in use exceed room count");

  a_peak_ge_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= cnt_r)
    else $error("peak below rooms in use");

  a_full_no_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_res |-> out_room == '0 &&
      out_occupied == lfra_pkg::ROOM_W'(lfra_pkg::MAX_ROOMS))
    else $error("full result with a room or free rooms left");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_LOOK)
    else $error("input transfer did not start a lookup");

  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    busy_req.wr_en |-> load && cust_req.wr_en)
    else $error("busy map written without a result and table update");

endmodule

[bench/tb_lowest_free_room_allocator.sv]
// Self-checking testbench for the lowest free room allocator: booking events in, room reports checked.
`timescale 1ns / 1ps

module tb_lowest_free_room_allocator;

  localparam int STUCK_LIMIT = 5000;
  localparam int TAIL_CYCLES = 12;
  localparam int CALM_TAIL   = 150;

  // One booking event waiting to be sent; hold_for_drain makes the sender wait
  // until every outstanding report has come back before presenting it.
  typedef struct {
    logic                        cmd;
    logic [lfra_pkg::CUST_W-1:0] cust;
    bit                          hold_for_drain;
  } booking_t;

  // One room report as the block should produce it
  typedef struct packed {
    logic [lfra_pkg::ROOM_W-1:0] room;
    logic [lfra_pkg::ROOM_W-1:0] occupied;
    logic [lfra_pkg::ROOM_W-1:0] peak;
    logic                        full_res;
  } room_report_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        in_cmd = lfra_pkg::CMD_ARRIVE;
  logic [lfra_pkg::CUST_W-1:0] in_customer = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [lfra_pkg::ROOM_W-1:0] out_room;
  logic [lfra_pkg::ROOM_W-1:0] out_occupied;
  logic [lfra_pkg::ROOM_W-1:0] out_peak;
  logic                        out_full_res;

  booking_t     booking_backlog[$];
  room_report_t room_reports[$];

  // Predicted allocator state
  logic [lfra_pkg::ROOM_W-1:0]    room_held[lfra_pkg::MAX_CUSTOMERS];
  logic [lfra_pkg::MAX_ROOMS-1:0] room_busy = '0;
  logic [lfra_pkg::ROOM_W-1:0]    rooms_in_use = '0;
  logic [lfra_pkg::ROOM_W-1:0]    rooms_peak = '0;

  // Generator shadow: who holds a room and whose table entry has been written
  bit [lfra_pkg::MAX_CUSTOMERS-1:0] gen_held = '0;
  bit [lfra_pkg::MAX_CUSTOMERS-1:0] gen_written = '0;
  int                               gen_held_cnt = 0;
  bit                               gen_drain_next = 1'b0;

  int mismatch_cnt = 0;
  int total_items  = 0;
  int sent_cnt     = 0;
  int send_gap     = 0;
  int sink_gap     = 0;
  int stuck_cycles = 0;
  logic idle_ok;

  lowest_free_room_allocator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_customer  (in_customer),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_room     (out_room),
    .out_occupied (out_occupied),
    .out_peak     (out_peak),
    .out_full_res (out_full_res)
  );

  // Clock and reset
  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Idle bursts only in some stretches, never near the end
  assign idle_ok = ((sent_cnt % 400) < 300) && (sent_cnt + CALM_TAIL < total_items);

  // Predict the report for one accepted event and update the predicted state
  task automatic book_event(input logic cmd, input logic [lfra_pkg::CUST_W-1:0] cust);
    room_report_t rpt;
    logic [lfra_pkg::ROOM_W-1:0] held;
    int free_room;
    rpt = '0;
    held = room_held[cust];
    if (cmd == lfra_pkg::CMD_ARRIVE) begin
      if (held != '0) begin
        // repeated arrival: report the room already held
        rpt.room = held;
      end else begin
        free_room = 0;
        for (int r = lfra_pkg::MAX_ROOMS - 1; r >= 0; r--) begin
          if (!room_busy[r]) free_room = r + 1;
        end
        if (free_room == 0) begin
          rpt.full_res = 1'b1;
        end else begin
          room_busy[free_room-1] = 1'b1;
          room_held[cust] = lfra_pkg::ROOM_W'(free_room);
          rooms_in_use = rooms_in_use + 1'b1;
          rpt.room = lfra_pkg::ROOM_W'(free_room);
        end
      end
    end else if (held != '0) begin
      // departure frees the held room; without a room nothing changes
      room_busy[held-1] = 1'b0;
      room_held[cust] = '0;
      if (rooms_in_use != '0) rooms_in_use = rooms_in_use - 1'b1;
    end
    if (rooms_in_use > rooms_peak) rooms_peak = rooms_in_use;
    rpt.occupied = rooms_in_use;
    rpt.peak = rooms_peak;
    room_reports = {room_reports, rpt};
  endtask

  task automatic flag_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_cnt++;
  endtask

  // Queue one event and track who holds a room
  task automatic queue_booking(input logic cmd, input int cust);
    booking_t b;
    b.cmd = cmd;
    b.cust = lfra_pkg::CUST_W'(cust);
    b.hold_for_drain = gen_drain_next;
    gen_drain_next = 1'b0;
    booking_backlog = {booking_backlog, b};
    if (cmd == lfra_pkg::CMD_ARRIVE) begin
      if (!gen_held[cust]) gen_held_cnt++;
      gen_held[cust] = 1'b1;
      gen_written[cust] = 1'b1;
    end else begin
      if (gen_held[cust]) gen_held_cnt--;
      gen_held[cust] = 1'b0;
    end
  endtask

  // Mixed traffic: arrivals of any customer (repeats included), departures of
  // holders, and departures of customers that already left
  task automatic queue_mixed(input int n, input int arrive_pct);
    int pick;
    int c;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      c = $urandom_range(0, lfra_pkg::MAX_CUSTOMERS - 1);
      if (gen_held_cnt == 0 || pick < arrive_pct) begin
        queue_booking(lfra_pkg::CMD_ARRIVE, c);
      end else if (pick < 92) begin
        while (!gen_held[c]) c = $urandom_range(0, lfra_pkg::MAX_CUSTOMERS - 1);
        queue_booking(lfra_pkg::CMD_DEPART, c);
      end else if (gen_written[c]) begin
        queue_booking(lfra_pkg::CMD_DEPART, c);
      end else begin
        queue_booking(lfra_pkg::CMD_ARRIVE, c);
      end
    end
  endtask

  // Stimulus plan and end of run
  initial begin : stimulus
    int order[lfra_pkg::MAX_CUSTOMERS];
    int j;
    int tmp;
    int c;
    for (int i = 0; i < lfra_pkg::MAX_CUSTOMERS; i++) room_held[i] = '0;

    // Directed: first rooms, repeats, reuse of the lowest freed room,
    // departure without a room, customer index extremes and bit patterns
    queue_booking(lfra_pkg::CMD_ARRIVE, 0);
    queue_booking(lfra_pkg::CMD_ARRIVE, 1023);
    queue_booking(lfra_pkg::CMD_ARRIVE, 0);
    queue_booking(lfra_pkg::CMD_ARRIVE, 512);
    queue_booking(lfra_pkg::CMD_DEPART, 0);
    queue_booking(lfra_pkg::CMD_DEPART, 0);
    queue_booking(lfra_pkg::CMD_ARRIVE, 341);
    queue_booking(lfra_pkg::CMD_ARRIVE, 682);
    queue_booking(lfra_pkg::CMD_DEPART, 1023);
    queue_booking(lfra_pkg::CMD_DEPART, 512);
    queue_booking(lfra_pkg::CMD_ARRIVE, 1);
    queue_booking(lfra_pkg::CMD_ARRIVE, 2);
    queue_booking(lfra_pkg::CMD_ARRIVE, 682);
    queue_booking(lfra_pkg::CMD_DEPART, 341);
    queue_booking(lfra_pkg::CMD_DEPART, 682);
    queue_booking(lfra_pkg::CMD_DEPART, 1);
    queue_booking(lfra_pkg::CMD_DEPART, 2);
    queue_booking(lfra_pkg::CMD_DEPART, 1023);
    queue_booking(lfra_pkg::CMD_ARRIVE, 0);
    queue_booking(lfra_pkg::CMD_DEPART, 0);

    // Random mixed traffic
    queue_mixed(300, 50);

    // Fill every room: all customers arrive in random order, with repeats mixed
    // in. With as many customers as rooms the full flag cannot be raised, since
    // any further arrival is a repeat.
    gen_drain_next = 1'b1;
    for (int i = 0; i < lfra_pkg::MAX_CUSTOMERS; i++) order[i] = i;
    for (int i = lfra_pkg::MAX_CUSTOMERS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < lfra_pkg::MAX_CUSTOMERS; i++) begin
      if (!gen_held[order[i]]) queue_booking(lfra_pkg::CMD_ARRIVE, order[i]);
      if ($urandom_range(0, 24) == 0) begin
        c = order[$urandom_range(0, i)];
        queue_booking(lfra_pkg::CMD_ARRIVE, c);
      end
    end

    // At full occupancy: repeats, then a few leave and come back
    for (int i = 0; i < 8; i++)
      queue_booking(lfra_pkg::CMD_ARRIVE, $urandom_range(0, lfra_pkg::MAX_CUSTOMERS - 1));
    for (int i = 0; i < 4; i++) order[i] = $urandom_range(0, lfra_pkg::MAX_CUSTOMERS - 1);
    for (int i = 0; i < 4; i++) queue_booking(lfra_pkg::CMD_DEPART, order[i]);
    for (int i = 0; i < 4; i++) queue_booking(lfra_pkg::CMD_ARRIVE, order[i]);

    // Draining traffic, mostly departures, then mixed again
    gen_drain_next = 1'b1;
    queue_mixed(150, 20);
    queue_mixed(100, 50);

    total_items = booking_backlog.size();

    @(posedge rst_n);
    while (booking_backlog.size() != 0 || room_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Sender: presents the backlog head, with idle bursts and a drain hold-off
  always @(posedge clk) begin
    logic fire;
    fire = in_valid && in_ready;
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_cmd      <= lfra_pkg::CMD_ARRIVE;
      in_customer <= '0;
      send_gap    <= 0;
    end else begin
      if (fire) begin
        book_event(in_cmd, in_customer);
        void'(booking_backlog.pop_front());
        sent_cnt <= sent_cnt + 1;
      end
      if (in_valid && !fire) begin
        // hold the pending transfer
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (booking_backlog.size() == 0 ||
                   (booking_backlog[0].hold_for_drain && room_reports.size() != 0)) begin
        in_valid <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else begin
        in_valid    <= 1'b1;
        in_cmd      <= booking_backlog[0].cmd;
        in_customer <= booking_backlog[0].cust;
      end
    end
  end

  // Receiver: ready with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_gap  <= 0;
    end else if (sink_gap > 0) begin
      sink_gap  <= sink_gap - 1;
      out_ready <= 1'b0;
    end else if (idle_ok && $urandom_range(0, 9) == 0) begin
      sink_gap  <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Checker: each report transfer against the oldest prediction
  always @(posedge clk) begin
    room_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (room_reports.size() == 0) begin
        flag_mismatch($sformatf("report with none expected (room %0d)", out_room));
      end else begin
        want = room_reports.pop_front();
        if (out_room !== want.room)
          flag_mismatch($sformatf("room %0d, want %0d", out_room, want.room));
        if (out_occupied !== want.occupied)
          flag_mismatch($sformatf("occupied %0d, want %0d", out_occupied, want.occupied));
        if (out_peak !== want.peak)
          flag_mismatch($sformatf("peak %0d, want %0d", out_peak, want.peak));
        if (out_full_res !== want.full_res)
          flag_mismatch($sformatf("full_res %0b, want %0b", out_full_res, want.full_res));
      end
    end
  end

  // Watchdog: too long without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
